FILE: hdl/wav_pcm_stream_parser_assert.svh
// Assertion macros used by the checker file.
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define WPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wps assertion failed");

// Next-cycle implication, held off during reset
`define WPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wps assertion failed");

// Next-cycle implication that also runs through reset
`define WPS_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("wps reset assertion failed");

`endif

FILE: hdl/wps_pkg.sv
`default_nettype none

package wps_pkg;

    // Parse phases
    typedef enum logic [3:0] {
        PH_ID        = 4'd0,
        PH_RIFF_LEN  = 4'd1,
        PH_RIFF_TYPE = 4'd2,
        PH_FMT_LEN   = 4'd3,
        PH_FMT_BODY  = 4'd4,
        PH_SKIP_LEN  = 4'd5,
        PH_SKIP      = 4'd6,
        PH_DATA_LEN  = 4'd7,
        PH_DATA      = 4'd8,
        PH_DONE      = 4'd9
    } t_phase;

    // Chunk tags as gathered little-endian
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
    localparam logic [31:0] RIFF_HDR_LEN = 32'd8;
    localparam logic [15:0] BITS_8       = 16'd8;
    localparam logic [15:0] BITS_16      = 16'd16;

    // Result kinds
    localparam logic [1:0] KIND_FORMAT   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE   = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;
    localparam logic [1:0] KIND_DATA_END = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_BAD_HEADER = 2'd0;
    localparam logic [1:0] ERR_NO_FMT     = 2'd1;
    localparam logic [1:0] ERR_SHORT_FMT  = 2'd2;
    localparam logic [1:0] ERR_EARLY_END  = 2'd3;

    // One result word plus its valid flag
    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic [15:0]        channel_index;
        logic [15:0]        channel_count;
        logic [31:0]        frame_rate;
        logic [15:0]        sample_bits;
        logic [15:0]        format_code;
        logic [1:0]         error_code;
        logic               last_sample;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/wps_core.sv
`default_nettype none

// Parser state and the one-byte step. State advances when i_en is high.
module wps_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_eos,
    input  wire logic [31:0]      i_total_length,
    output wps_pkg::t_result      o_res
);

    wps_pkg::t_phase r_phase, n_phase, w_step_phase;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_shift, n_shift;
    logic        r_fmt_seen, n_fmt_seen;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [15:0] r_format, n_format;
    logic [15:0] r_frame, n_frame;
    logic [7:0]  r_hold, n_hold;

    logic [31:0] w_word;
    logic        w_gdone;
    logic [31:0] w_rem_dec;
    logic [31:0] w_data_rem;
    logic        w_hdr_bad;
    logic        w_is16;
    logic        w_sample_go;
    logic [16:0] w_frame_inc;

    wps_pkg::t_result w_res;

    // Gather helpers
    assign w_word    = {i_byte, r_shift[31:8]};
    assign w_gdone   = (r_pos == 4'd3);
    assign w_rem_dec = r_rem - 32'd1;
    assign w_is16    = (r_bits == wps_pkg::BITS_16);
    assign w_hdr_bad = (r_rem != (i_total_length - wps_pkg::RIFF_HDR_LEN)) ||
                       (w_word != wps_pkg::TAG_WAVE);
    assign w_data_rem = w_is16 ? {1'b0, w_word[31:1]} :
                        (r_bits == wps_pkg::BITS_8) ? w_word : 32'd0;
    // a sample completes on every 8-bit byte, on the high byte for 16-bit
    assign w_sample_go = !w_is16 || (r_pos == 4'd1);
    assign w_frame_inc = {1'b0, r_frame} + 17'd1;

    // Next phase
    always_comb begin
        w_step_phase = r_phase;
        unique case (r_phase)
            wps_pkg::PH_ID: begin
                if (w_gdone) begin
                    if (w_word == wps_pkg::TAG_RIFF)
                        w_step_phase = wps_pkg::PH_RIFF_LEN;
                    else if (w_word == wps_pkg::TAG_FMT)
                        w_step_phase = wps_pkg::PH_FMT_LEN;
                    else if (w_word == wps_pkg::TAG_DATA)
                        w_step_phase = r_fmt_seen ? wps_pkg::PH_DATA_LEN : wps_pkg::PH_DONE;
                    else
                        w_step_phase = wps_pkg::PH_SKIP_LEN;
                end
            end
            wps_pkg::PH_RIFF_LEN: begin
                if (w_gdone) w_step_phase = wps_pkg::PH_RIFF_TYPE;
            end
            wps_pkg::PH_RIFF_TYPE: begin
                if (w_gdone) w_step_phase = w_hdr_bad ? wps_pkg::PH_DONE : wps_pkg::PH_ID;
            end
            wps_pkg::PH_FMT_LEN: begin
                if (w_gdone)
                    w_step_phase = (w_word < wps_pkg::FMT_MIN_LEN) ? wps_pkg::PH_DONE
                                                                   : wps_pkg::PH_FMT_BODY;
            end
            wps_pkg::PH_FMT_BODY: begin
                if (r_pos == 4'd15)
                    w_step_phase = (r_rem != 32'd0) ? wps_pkg::PH_SKIP : wps_pkg::PH_ID;
            end
            wps_pkg::PH_SKIP_LEN: begin
                if (w_gdone)
                    w_step_phase = (w_word != 32'd0) ? wps_pkg::PH_SKIP : wps_pkg::PH_ID;
            end
            wps_pkg::PH_SKIP: begin
                if (r_rem == 32'd1) w_step_phase = wps_pkg::PH_ID;
            end
            wps_pkg::PH_DATA_LEN: begin
                if (w_gdone)
                    w_step_phase = (w_data_rem == 32'd0) ? wps_pkg::PH_DONE : wps_pkg::PH_DATA;
            end
            wps_pkg::PH_DATA: begin
                if (w_sample_go && r_rem == 32'd1) w_step_phase = wps_pkg::PH_DONE;
            end
            default: w_step_phase = wps_pkg::PH_DONE;
        endcase
        // end of stream before parsing ends stops everything
        n_phase = i_eos ? wps_pkg::PH_DONE : w_step_phase;
    end

    // Datapath updates and the result word
    always_comb begin
        n_pos      = r_pos;
        n_rem      = r_rem;
        n_shift    = r_shift;
        n_fmt_seen = r_fmt_seen;
        n_channels = r_channels;
        n_rate     = r_rate;
        n_bits     = r_bits;
        n_format   = r_format;
        n_frame    = r_frame;
        n_hold     = r_hold;
        w_res      = '0;
        unique case (r_phase)
            wps_pkg::PH_ID, wps_pkg::PH_RIFF_LEN, wps_pkg::PH_RIFF_TYPE,
            wps_pkg::PH_FMT_LEN, wps_pkg::PH_SKIP_LEN, wps_pkg::PH_DATA_LEN: begin
                n_shift = w_word;
                n_pos   = w_gdone ? 4'd0 : r_pos + 4'd1;
                if (w_gdone) begin
                    unique case (r_phase)
                        wps_pkg::PH_ID: begin
                            if (w_word == wps_pkg::TAG_DATA && !r_fmt_seen) begin
                                w_res.valid      = 1'b1;
                                w_res.kind       = wps_pkg::KIND_ERROR;
                                w_res.error_code = wps_pkg::ERR_NO_FMT;
                            end
                        end
                        wps_pkg::PH_RIFF_LEN: n_rem = w_word;
                        wps_pkg::PH_RIFF_TYPE: begin
                            n_rem = 32'd0;
                            if (w_hdr_bad) begin
                                w_res.valid      = 1'b1;
                                w_res.kind       = wps_pkg::KIND_ERROR;
                                w_res.error_code = wps_pkg::ERR_BAD_HEADER;
                            end
                        end
                        wps_pkg::PH_FMT_LEN: begin
                            if (w_word < wps_pkg::FMT_MIN_LEN) begin
                                w_res.valid      = 1'b1;
                                w_res.kind       = wps_pkg::KIND_ERROR;
                                w_res.error_code = wps_pkg::ERR_SHORT_FMT;
                            end else begin
                                n_rem = w_word - wps_pkg::FMT_MIN_LEN;
                            end
                        end
                        wps_pkg::PH_SKIP_LEN: n_rem = w_word;
                        default: begin
                            // data length
                            n_frame = 16'd0;
                            n_rem   = w_data_rem;
                            if (w_data_rem == 32'd0) begin
                                w_res.valid = 1'b1;
                                w_res.kind  = wps_pkg::KIND_DATA_END;
                            end
                        end
                    endcase
                end
            end
            wps_pkg::PH_FMT_BODY: begin
                n_pos = r_pos + 4'd1;
                case (r_pos)
                    4'd0:  n_format[7:0]    = i_byte;
                    4'd1:  n_format[15:8]   = i_byte;
                    4'd2:  n_channels[7:0]  = i_byte;
                    4'd3:  n_channels[15:8] = i_byte;
                    4'd4:  n_rate[7:0]      = i_byte;
                    4'd5:  n_rate[15:8]     = i_byte;
                    4'd6:  n_rate[23:16]    = i_byte;
                    4'd7:  n_rate[31:24]    = i_byte;
                    4'd14: n_bits[7:0]      = i_byte;
                    4'd15: n_bits[15:8]     = i_byte;
                    default: ;
                endcase
                if (r_pos == 4'd15) begin
                    n_fmt_seen          = 1'b1;
                    w_res.valid         = 1'b1;
                    w_res.kind          = wps_pkg::KIND_FORMAT;
                    w_res.channel_count = r_channels;
                    w_res.frame_rate    = r_rate;
                    w_res.sample_bits   = {i_byte, r_bits[7:0]};
                    w_res.format_code   = r_format;
                end
            end
            wps_pkg::PH_SKIP: n_rem = w_rem_dec;
            wps_pkg::PH_DATA: begin
                if (w_is16 && r_pos == 4'd0) begin
                    n_hold = i_byte;
                    n_pos  = 4'd1;
                end else begin
                    if (w_is16) n_pos = 4'd0;
                    n_rem               = w_rem_dec;
                    n_frame             = (w_frame_inc >= {1'b0, r_channels}) ? 16'd0
                                                                              : w_frame_inc[15:0];
                    w_res.valid         = 1'b1;
                    w_res.kind          = wps_pkg::KIND_SAMPLE;
                    w_res.sample_value  = w_is16 ? {i_byte, r_hold}
                                                 : {i_byte ^ 8'h80, 8'h00};
                    w_res.channel_index = r_frame;
                    w_res.last_sample   = (w_rem_dec == 32'd0);
                end
            end
            default: ;
        endcase
        // early end replaces any other result
        if (i_eos && w_step_phase != wps_pkg::PH_DONE) begin
            w_res            = '0;
            w_res.valid      = 1'b1;
            w_res.kind       = wps_pkg::KIND_ERROR;
            w_res.error_code = wps_pkg::ERR_EARLY_END;
        end
        w_res.valid = w_res.valid & i_en;
    end

    assign o_res = w_res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= wps_pkg::PH_ID;
            r_pos      <= 4'd0;
            r_rem      <= 32'd0;
            r_shift    <= 32'd0;
            r_fmt_seen <= 1'b0;
            r_channels <= 16'd0;
            r_rate     <= 32'd0;
            r_bits     <= 16'd0;
            r_format   <= 16'd0;
            r_frame    <= 16'd0;
            r_hold     <= 8'd0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_rem      <= n_rem;
            r_shift    <= n_shift;
            r_fmt_seen <= n_fmt_seen;
            r_channels <= n_channels;
            r_rate     <= n_rate;
            r_bits     <= n_bits;
            r_format   <= n_format;
            r_frame    <= n_frame;
            r_hold     <= n_hold;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wav_pcm_stream_parser.sv
// Channel   | Dir | Handshake          | Word
// ----------+-----+--------------------+-------------------------------------------
// byte in   | in  | i_valid / o_stall  | i_byte_value, i_end_of_stream
// result    | out | o_valid / i_stall  | o_kind, o_sample_value, ... o_last_sample
// config    | in  | i_cfg_wr_en        | i_cfg_wr_data (total length)
//
// One byte per cycle while no held result stalls the input; a byte taken sits in the
// input register, then the parse step loads its result into the result register.
// Reset is synchronous and active low; no clearing pass.
// i_stall holds the result register; the input register keeps taking bytes while
// the step has room, and o_stall rises only when a byte waits on a held result.
`default_nettype none

module wav_pcm_stream_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte in
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic               i_end_of_stream,
    // config
    input  wire logic               i_cfg_wr_en,
    input  wire logic [31:0]        i_cfg_wr_data,
    // result
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_kind,
    output logic signed [15:0]      o_sample_value,
    output logic [15:0]             o_channel_index,
    output logic [15:0]             o_channel_count,
    output logic [31:0]             o_frame_rate,
    output logic [15:0]             o_sample_bits,
    output logic [15:0]             o_format_code,
    output logic [1:0]              o_error_code,
    output logic                    o_last_sample
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;
    logic [31:0] r_total_len;
    logic        w_out_free;
    logic        w_fire;

    wps_pkg::t_result w_res;
    wps_pkg::t_result r_out;

    assign w_out_free = !r_out.valid || !i_stall;
    assign w_fire     = r_in_vld && w_out_free;
    assign o_stall    = r_in_vld && !w_out_free;

    // Total length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_len <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_total_len <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_byte_value;
            r_in_eos  <= i_end_of_stream;
        end
    end

    // Parse step
    wps_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_fire),
        .i_byte         (r_in_byte),
        .i_eos          (r_in_eos),
        .i_total_length (r_total_len),
        .o_res          (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (w_fire) begin
            r_out <= w_res;
        end else if (!i_stall) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_valid         = r_out.valid;
    assign o_kind          = r_out.kind;
    assign o_sample_value  = r_out.sample_value;
    assign o_channel_index = r_out.channel_index;
    assign o_channel_count = r_out.channel_count;
    assign o_frame_rate    = r_out.frame_rate;
    assign o_sample_bits   = r_out.sample_bits;
    assign o_format_code   = r_out.format_code;
    assign o_error_code    = r_out.error_code;
    assign o_last_sample   = r_out.last_sample;

endmodule

`default_nettype wire

FILE: hdl/wps_checker.sv
`default_nettype none

`include "wav_pcm_stream_parser_assert.svh"

// Port-level checks on the parser
module wps_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [1:0]         o_kind,
    input wire logic signed [15:0] o_sample_value,
    input wire logic [15:0]        o_channel_index,
    input wire logic [15:0]        o_channel_count,
    input wire logic [31:0]        o_frame_rate,
    input wire logic [15:0]        o_sample_bits,
    input wire logic [15:0]        o_format_code,
    input wire logic               o_last_sample
);

    logic         w_out_held;
    logic [114:0] w_out_word;
    logic         w_final_taken;
    logic         w_smp_clear;
    logic         w_fmt_clear;

    assign w_out_held    = o_valid && i_stall;
    assign w_out_word    = {o_kind, o_sample_value, o_channel_index, o_channel_count,
                            o_frame_rate, o_sample_bits, o_format_code, o_last_sample};
    assign w_final_taken = o_valid && !i_stall &&
                           (o_kind == wps_pkg::KIND_ERROR ||
                            o_kind == wps_pkg::KIND_DATA_END || o_last_sample);
    assign w_smp_clear   = (o_sample_value == 16'sd0) && (o_channel_index == 16'd0) &&
                           !o_last_sample;
    assign w_fmt_clear   = (o_channel_count == 16'd0) && (o_frame_rate == 32'd0) &&
                           (o_sample_bits == 16'd0) && (o_format_code == 16'd0);

    // held result keeps its word
    `WPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_held, o_valid && $stable(w_out_word))

    // nothing follows an error, a data end or the last sample
    `WPS_ASSERT_NXT(a_final_word, i_clk, i_rst_n, w_final_taken, !o_valid)

    // sample fields are zero outside sample words
    `WPS_ASSERT_IMP(a_sample_zero, i_clk, i_rst_n, o_valid && o_kind != wps_pkg::KIND_SAMPLE, w_smp_clear)

    // format fields are zero outside format words
    `WPS_ASSERT_IMP(a_format_zero, i_clk, i_rst_n, o_valid && o_kind != wps_pkg::KIND_FORMAT, w_fmt_clear)

    // reset empties both sides
    `WPS_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_sample_value  (o_sample_value),
    .o_channel_index (o_channel_index),
    .o_channel_count (o_channel_count),
    .o_frame_rate    (o_frame_rate),
    .o_sample_bits   (o_sample_bits),
    .o_format_code   (o_format_code),
    .o_last_sample   (o_last_sample)
);

`default_nettype wire
